>>> rtl/sia_pkg.sv
// Shared types for the saturating interval ALU: opcodes and the stage advance bundle.
// No dependencies.
package sia_pkg;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_SUB      = 3'd1,
        OP_MUL      = 3'd2,
        OP_ISECT    = 3'd3,
        OP_HOLDS    = 3'd4,
        OP_CONTAINS = 3'd5,
        OP_SIZE     = 3'd6,
        OP_EQUAL    = 3'd7
    } sia_op_t;

    // load enables of the multiplier's two register stages
    typedef struct packed {
        logic s2;
        logic s3;
    } sia_adv_t;

    localparam int FIELD_BITS = 32;

endpackage

>>> rtl/sia_mul.sv
// Two-stage saturating multiplier lane: partial products, then sum and clamp.
// Depends on sia_pkg.
module sia_mul import sia_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  sia_adv_t              adv,
    input  logic [VALUE_BITS-1:0] x,
    input  logic [VALUE_BITS-1:0] y,
    output logic [VALUE_BITS-1:0] prod
);

    localparam int H = (VALUE_BITS + 1) / 2;
    localparam logic [VALUE_BITS-1:0] INF = {VALUE_BITS{1'b1}};

    logic [2*H-1:0] xe, ye;
    logic [2*H-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic           zero_reg, inf_reg;
    logic [2*H:0]   mid;
    logic [4*H-1:0] full;
    logic [VALUE_BITS-1:0] prod_reg, prod_next;

    assign xe = (2*H)'(x);
    assign ye = (2*H)'(y);

    // split each factor in halves so no multiplier exceeds H by H bits
    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            pp_ll_reg <= xe[H-1:0]   * ye[H-1:0];
            pp_lh_reg <= xe[H-1:0]   * ye[2*H-1:H];
            pp_hl_reg <= xe[2*H-1:H] * ye[H-1:0];
            pp_hh_reg <= xe[2*H-1:H] * ye[2*H-1:H];
            zero_reg  <= (x == '0) || (y == '0);
            inf_reg   <= (x == INF) || (y == INF);
        end
    end

    assign mid  = (2*H+1)'(pp_lh_reg) + (2*H+1)'(pp_hl_reg);
    assign full = {pp_hh_reg, pp_ll_reg} + ((4*H)'(mid) << H);

    always_comb begin
        if (zero_reg) begin
            prod_next = '0;
        end else if (inf_reg || (full >= (4*H)'(INF))) begin
            prod_next = INF;
        end else begin
            prod_next = full[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/sia_alu.sv
// Non-multiply arithmetic of one request: saturating add and subtract, intersection,
// membership and equality flags and size of A. Depends on sia_pkg.
module sia_alu import sia_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  sia_op_t               op,
    input  logic [VALUE_BITS-1:0] a_lo,
    input  logic [VALUE_BITS-1:0] a_hi,
    input  logic [VALUE_BITS-1:0] b_lo,
    input  logic [VALUE_BITS-1:0] b_hi,
    input  logic [VALUE_BITS-1:0] probe,
    input  logic                  a_empty,
    input  logic                  b_empty,
    output logic [VALUE_BITS-1:0] r_lo,
    output logic [VALUE_BITS-1:0] r_hi,
    output logic                  force_empty,
    output logic                  flag,
    output logic [VALUE_BITS-1:0] size
);

    localparam logic [VALUE_BITS-1:0] INF = {VALUE_BITS{1'b1}};

    function automatic logic [VALUE_BITS-1:0] sat_add(
        input logic [VALUE_BITS-1:0] p,
        input logic [VALUE_BITS-1:0] q
    );
        logic [VALUE_BITS:0] s;
        s = {1'b0, p} + {1'b0, q};
        return (s >= {1'b0, INF}) ? INF : s[VALUE_BITS-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] sat_sub(
        input logic [VALUE_BITS-1:0] p,
        input logic [VALUE_BITS-1:0] q
    );
        logic [VALUE_BITS-1:0] d;
        d = p - q;
        if (p <= q) begin
            d = '0;
        end else if (p == INF) begin
            d = INF;
        end
        return d;
    endfunction

    logic holds_probe, holds_blo, holds_bhi;

    assign holds_probe = (a_lo <= probe) && (probe <= a_hi);
    assign holds_blo   = (a_lo <= b_lo) && (b_lo <= a_hi);
    assign holds_bhi   = (a_lo <= b_hi) && (b_hi <= a_hi);

    always_comb begin
        r_lo        = '0;
        r_hi        = '0;
        force_empty = 1'b0;
        flag        = 1'b0;
        size        = '0;
        case (op)
            OP_ADD: begin
                r_lo        = sat_add(a_lo, b_lo);
                r_hi        = sat_add(a_hi, b_hi);
                force_empty = a_empty || b_empty;
            end
            OP_SUB: begin
                r_lo        = sat_sub(a_lo, b_hi);
                r_hi        = sat_sub(a_hi, b_lo);
                force_empty = a_empty || b_empty;
            end
            OP_MUL: begin
                force_empty = a_empty || b_empty;
            end
            OP_ISECT: begin
                r_lo = (a_lo > b_lo) ? a_lo : b_lo;
                r_hi = (a_hi < b_hi) ? a_hi : b_hi;
            end
            OP_HOLDS:    flag = holds_probe;
            OP_CONTAINS: flag = holds_blo && holds_bhi;
            OP_SIZE: begin
                if (a_hi == INF) begin
                    size = (a_lo == INF) ? '0 : INF;
                end else begin
                    size = a_hi - a_lo + VALUE_BITS'(1'b1);
                end
            end
            OP_EQUAL:    flag = (a_lo == b_lo) && (a_hi == b_hi);
            default: ;
        endcase
    end

endmodule

>>> rtl/sia_result.sv
// Final stage logic: pick the interval, canonicalize it and format the 32-bit result fields.
// Depends on sia_pkg.
module sia_result import sia_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  sia_op_t               op,
    input  logic [VALUE_BITS-1:0] r_lo,
    input  logic [VALUE_BITS-1:0] r_hi,
    input  logic [VALUE_BITS-1:0] mul_lo,
    input  logic [VALUE_BITS-1:0] mul_hi,
    input  logic                  force_empty,
    input  logic                  flag,
    input  logic [VALUE_BITS-1:0] size,
    output logic [FIELD_BITS-1:0] res_min,
    output logic [FIELD_BITS-1:0] res_max,
    output logic                  res_empty,
    output logic                  res_flag,
    output logic [FIELD_BITS-1:0] res_size
);

    localparam logic [VALUE_BITS-1:0] INF = {VALUE_BITS{1'b1}};
    localparam int W = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    logic [VALUE_BITS-1:0] lo, hi, c_lo, c_hi;
    logic [W-1:0]          lo_w, hi_w, size_w;
    logic                  is_ival;

    assign lo = (op == OP_MUL) ? mul_lo : r_lo;
    assign hi = (op == OP_MUL) ? mul_hi : r_hi;

    // collapse to the canonical empty interval
    assign c_lo = (force_empty || (hi < lo)) ? INF : lo;
    assign c_hi = (force_empty || (hi < lo)) ? INF : hi;

    assign is_ival = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_ISECT);

    assign lo_w   = W'(c_lo);
    assign hi_w   = W'(c_hi);
    assign size_w = W'(size);

    assign res_min   = is_ival ? lo_w[FIELD_BITS-1:0] : '0;
    assign res_max   = is_ival ? hi_w[FIELD_BITS-1:0] : '0;
    assign res_empty = is_ival && (c_lo == INF);
    assign res_flag  = flag;
    assign res_size  = size_w[FIELD_BITS-1:0];

endmodule

>>> rtl/saturating_interval_alu_unit.sv
// Top level of the saturating interval ALU: four-stage pipeline with per-stage stall.
// Depends on sia_pkg, sia_alu, sia_mul and sia_result.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------------
//  s_      | in  | s_valid / s_ready  | req_type, a_min, a_max, b_min, b_max, probe_value
//  m_      | out | m_valid / m_ready  | res_min, res_max, res_empty, res_flag, res_size
//
// m_valid rises once an accepted beat has moved through the stage 1, 2 and 3 registers into
// the output register. One beat can enter per cycle while the first stage is not stalled.
// Stages: canonicalize operands, ALU plus partial products, product sum and clamp,
// result select into the output register. The product sum sets the longest path.
// Each stage holds while its successor is full and stalled; bubbles still fill up.
// aresetn (synchronous) clears the stage valid bits only.
module saturating_interval_alu_unit import sia_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_a_min,
    input  logic [31:0] s_a_max,
    input  logic [31:0] s_b_min,
    input  logic [31:0] s_b_max,
    input  logic [31:0] s_probe_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_res_min,
    output logic [31:0] m_res_max,
    output logic        m_res_empty,
    output logic        m_res_flag,
    output logic [31:0] m_res_size
);

    localparam logic [VALUE_BITS-1:0] INF = {VALUE_BITS{1'b1}};
    localparam int W = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    // ---------------- stage control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: mask and canonicalize ----------------
    function automatic logic [VALUE_BITS-1:0] fit(input logic [31:0] f);
        logic [W-1:0] t;
        t = W'(f);
        return t[VALUE_BITS-1:0];
    endfunction

    logic [VALUE_BITS-1:0] a_lo_m, a_hi_m, b_lo_m, b_hi_m;
    logic                  a_bad, b_bad;

    assign a_lo_m = fit(s_a_min);
    assign a_hi_m = fit(s_a_max);
    assign b_lo_m = fit(s_b_min);
    assign b_hi_m = fit(s_b_max);
    assign a_bad  = a_hi_m < a_lo_m;
    assign b_bad  = b_hi_m < b_lo_m;

    sia_op_t               s1_op_reg;
    logic [VALUE_BITS-1:0] s1_a_lo_reg, s1_a_hi_reg, s1_b_lo_reg, s1_b_hi_reg, s1_probe_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_op_reg    <= sia_op_t'(s_req_type);
            s1_a_lo_reg  <= a_bad ? INF : a_lo_m;
            s1_a_hi_reg  <= a_bad ? INF : a_hi_m;
            s1_b_lo_reg  <= b_bad ? INF : b_lo_m;
            s1_b_hi_reg  <= b_bad ? INF : b_hi_m;
            s1_probe_reg <= fit(s_probe_value);
        end
    end

    // ---------------- stage 2: ALU, multiplier partial products ----------------
    logic [VALUE_BITS-1:0] alu_lo, alu_hi, alu_size;
    logic                  alu_force, alu_flag;

    sia_alu #(.VALUE_BITS(VALUE_BITS)) u_alu (
        .op          (s1_op_reg),
        .a_lo        (s1_a_lo_reg),
        .a_hi        (s1_a_hi_reg),
        .b_lo        (s1_b_lo_reg),
        .b_hi        (s1_b_hi_reg),
        .probe       (s1_probe_reg),
        .a_empty     (s1_a_lo_reg == INF),
        .b_empty     (s1_b_lo_reg == INF),
        .r_lo        (alu_lo),
        .r_hi        (alu_hi),
        .force_empty (alu_force),
        .flag        (alu_flag),
        .size        (alu_size)
    );

    sia_adv_t              mul_adv;
    logic [VALUE_BITS-1:0] mul_lo, mul_hi;

    assign mul_adv.s2 = rdy2;
    assign mul_adv.s3 = rdy3;

    sia_mul #(.VALUE_BITS(VALUE_BITS)) u_mul_lo (
        .aclk (aclk),
        .adv  (mul_adv),
        .x    (s1_a_lo_reg),
        .y    (s1_b_lo_reg),
        .prod (mul_lo)
    );

    sia_mul #(.VALUE_BITS(VALUE_BITS)) u_mul_hi (
        .aclk (aclk),
        .adv  (mul_adv),
        .x    (s1_a_hi_reg),
        .y    (s1_b_hi_reg),
        .prod (mul_hi)
    );

    sia_op_t               s2_op_reg, s3_op_reg;
    logic [VALUE_BITS-1:0] s2_lo_reg, s2_hi_reg, s2_size_reg;
    logic [VALUE_BITS-1:0] s3_lo_reg, s3_hi_reg, s3_size_reg;
    logic                  s2_force_reg, s2_flag_reg, s3_force_reg, s3_flag_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_op_reg    <= s1_op_reg;
            s2_lo_reg    <= alu_lo;
            s2_hi_reg    <= alu_hi;
            s2_force_reg <= alu_force;
            s2_flag_reg  <= alu_flag;
            s2_size_reg  <= alu_size;
        end
    end

    // ---------------- stage 3: carry ALU results beside the product sum ----------------
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_op_reg    <= s2_op_reg;
            s3_lo_reg    <= s2_lo_reg;
            s3_hi_reg    <= s2_hi_reg;
            s3_force_reg <= s2_force_reg;
            s3_flag_reg  <= s2_flag_reg;
            s3_size_reg  <= s2_size_reg;
        end
    end

    // ---------------- stage 4: select, canonicalize, output register ----------------
    logic [31:0] res_min, res_max, res_size;
    logic        res_empty, res_flag;

    sia_result #(.VALUE_BITS(VALUE_BITS)) u_result (
        .op          (s3_op_reg),
        .r_lo        (s3_lo_reg),
        .r_hi        (s3_hi_reg),
        .mul_lo      (mul_lo),
        .mul_hi      (mul_hi),
        .force_empty (s3_force_reg),
        .flag        (s3_flag_reg),
        .size        (s3_size_reg),
        .res_min     (res_min),
        .res_max     (res_max),
        .res_empty   (res_empty),
        .res_flag    (res_flag),
        .res_size    (res_size)
    );

    logic [31:0] m_min_reg, m_max_reg, m_size_reg;
    logic        m_empty_reg, m_flag_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            m_min_reg   <= res_min;
            m_max_reg   <= res_max;
            m_empty_reg <= res_empty;
            m_flag_reg  <= res_flag;
            m_size_reg  <= res_size;
        end
    end

    assign m_res_min   = m_min_reg;
    assign m_res_max   = m_max_reg;
    assign m_res_empty = m_empty_reg;
    assign m_res_flag  = m_flag_reg;
    assign m_res_size  = m_size_reg;

    // ---------------- checks ----------------
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !v4_reg |-> s_ready)
        else $error("input stalled while output stage is empty");

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted beat missing from first stage");

    a_stall_holds_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !rdy3 |=> v3_reg && $stable(s3_op_reg))
        else $error("stalled third stage lost its beat");

    a_empty_canonical: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res_empty |-> (m_res_min == m_res_max) && !m_res_flag)
        else $error("empty result not canonical");

    a_flag_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res_flag |-> (m_res_size == 32'd0) && (m_res_min == 32'd0))
        else $error("flag result carries interval or size data");

endmodule
